[hdl/ksd_pkg.sv]
// shared types, constants and keymap for the keypad scanner
package ksd_pkg;

  localparam int unsigned HistoryBitsDef = 8;
  localparam int unsigned NumCols        = 4;
  localparam int unsigned NumRows        = 4;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef logic [1:0] col_t;
  typedef logic [3:0] idx_t;
  typedef logic [3:0] rows_t;
  typedef logic [6:0] char_t;

  typedef struct packed {
    logic valid;
    idx_t idx;
  } slot_t;

  // keymap "DCBA#9630852*741", ascii
  localparam char_t KeyMap [16] = '{
    7'h44, 7'h43, 7'h42, 7'h41, 7'h23, 7'h39, 7'h36, 7'h33,
    7'h30, 7'h38, 7'h35, 7'h32, 7'h2A, 7'h37, 7'h34, 7'h31
  };

endpackage

[hdl/ksd_if.sv]
// valid/ready channel interfaces for scan commands and key results
interface ksd_in_if;
  import ksd_pkg::*;
  logic  valid;
  logic  ready;
  cmd_e  command;
  rows_t rows;
  modport source (output valid, output command, output rows, input ready);
  modport sink   (input valid, input command, input rows, output ready);
endinterface

interface ksd_out_if;
  import ksd_pkg::*;
  logic  valid;
  logic  ready;
  col_t  column_drive;
  logic  key_valid;
  idx_t  key_index;
  char_t key_char;
  modport source (output valid, output column_drive, output key_valid,
                  output key_index, output key_char, input ready);
  modport sink   (input valid, input column_drive, input key_valid,
                  input key_index, input key_char, output ready);
endinterface

[hdl/ksd_history.sv]
// key history memory, one row per column, with shift and press detection
module ksd_history #(
  parameter int unsigned HistoryBits = ksd_pkg::HistoryBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  ksd_pkg::col_t rd_addr_i,
  input  logic          upd_en_i,
  input  ksd_pkg::col_t upd_col_i,
  input  ksd_pkg::rows_t upd_rows_i,
  output ksd_pkg::rows_t press_o
);
  import ksd_pkg::*;

  localparam int unsigned RowW = NumRows * HistoryBits;

  logic [RowW-1:0]    mem_q [NumCols];
  logic [RowW-1:0]    rd_data_q;
  logic               rd_vld_q;
  logic [NumCols-1:0] row_vld_q;
  logic [RowW-1:0]    old_row;
  logic [RowW-1:0]    new_row;

  // rows never written read as zero history
  assign old_row = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      new_row[r*HistoryBits +: HistoryBits] =
        {old_row[r*HistoryBits +: HistoryBits-1], upd_rows_i[r]};
      press_o[r] = new_row[r*HistoryBits +: HistoryBits] ==
                   {{(HistoryBits-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    if (upd_en_i) begin
      mem_q[upd_col_i] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
      if (upd_en_i) begin
        row_vld_q[upd_col_i] <= 1'b1;
      end
    end
  end

endmodule

[hdl/keypad_scan_debounce.sv]
// 4x4 keypad scanner: history memory, event ring and result register
// result path: a command is held in stage s1, then in the result register
// throughput: one command per cycle unless stalled; a history row is
//   read at accept, written back one stage later, recurs every fourth tick
// reset: histories read as zero via per-row valid bits, column, ring and
//   pointers cleared at once; no clearing pass
module keypad_scan_debounce #(
  parameter int unsigned HistoryBits = ksd_pkg::HistoryBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ksd_in_if.sink    in_i,
  ksd_out_if.source out_o
);
  import ksd_pkg::*;

  col_t  col_q, col_d;
  logic  s1_vld_q;
  cmd_e  s1_cmd_q;
  rows_t s1_rows_q;
  col_t  s1_col_q;
  slot_t slots_q [2];
  slot_t slots_d [2];
  logic  wr_q, wr_d, rd_q, rd_d;
  logic  out_vld_q;
  col_t  out_col_q, out_col_d;
  logic  out_kv_q, out_kv_d;
  idx_t  out_idx_q, out_idx_d;
  char_t out_char_q, out_char_d;
  rows_t press;
  logic  adv, s1_go, acc;

  assign adv        = !out_vld_q || out_o.ready;
  assign s1_go      = s1_vld_q && adv;
  assign in_i.ready = !s1_vld_q || adv;
  assign acc        = in_i.valid && in_i.ready;

  assign col_d = (acc && in_i.command == CMD_TICK) ? col_q + 2'd1 : col_q;

  ksd_history #(.HistoryBits(HistoryBits)) u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (acc),
    .rd_addr_i  (col_q),
    .upd_en_i   (s1_go && s1_cmd_q == CMD_TICK),
    .upd_col_i  (s1_col_q),
    .upd_rows_i (s1_rows_q),
    .press_o    (press)
  );

  // ring update: presses pushed in row order, overwrite without full check
  always_comb begin
    slots_d    = slots_q;
    wr_d       = wr_q;
    rd_d       = rd_q;
    out_col_d  = s1_col_q;
    out_kv_d   = 1'b0;
    out_idx_d  = '0;
    out_char_d = '0;
    if (s1_cmd_q == CMD_TICK) begin
      out_col_d = s1_col_q + 2'd1;
      if (s1_go) begin
        for (int i = 0; i < NumRows; i++) begin
          if (press[i]) begin
            slots_d[wr_d] = '{valid: 1'b1, idx: {s1_col_q, 2'(i)}};
            wr_d          = ~wr_d;
          end
        end
      end
    end else if (slots_q[rd_q].valid) begin
      out_kv_d   = 1'b1;
      out_idx_d  = slots_q[rd_q].idx;
      out_char_d = KeyMap[slots_q[rd_q].idx];
      if (s1_go) begin
        slots_d[rd_q] = '0;
        rd_d          = ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      s1_vld_q  <= 1'b0;
      slots_q   <= '{default: '0};
      wr_q      <= 1'b0;
      rd_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      slots_q <= slots_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      if (acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_go) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_cmd_q  <= in_i.command;
      s1_rows_q <= in_i.rows;
      s1_col_q  <= col_q;
    end
    if (s1_go) begin
      out_col_q  <= out_col_d;
      out_kv_q   <= out_kv_d;
      out_idx_q  <= out_idx_d;
      out_char_q <= out_char_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.column_drive = out_col_q;
  assign out_o.key_valid    = out_kv_q;
  assign out_o.key_index    = out_idx_q;
  assign out_o.key_char     = out_char_q;

  a_char_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_kv_q |-> out_char_q == KeyMap[out_idx_q])
    else $error("key char does not match keymap");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_kv_q |-> out_idx_q == '0 && out_char_q == '0)
    else $error("result without key carries nonzero key fields");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !adv |-> !in_i.ready)
    else $error("input taken while stage is blocked");

  a_tick_advances_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.command == CMD_TICK |=> col_q == $past(col_q) + 2'd1)
    else $error("column did not advance on tick");

  a_pop_moves_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_cmd_q == CMD_POP && slots_q[rd_q].valid |=> rd_q != $past(rd_q))
    else $error("read slot did not move on successful pop");

endmodule

[tb/sv/tb_keypad_scan_debounce.sv]
// testbench for the keypad scanner: directed and random commands checked by a scoreboard
module tb_keypad_scan_debounce;
  timeunit 1ns;
  timeprecision 1ps;

  import ksd_pkg::*;

  localparam int unsigned HistBits = HistoryBitsDef;

  typedef struct packed {
    col_t  col;
    logic  key_valid;
    idx_t  idx;
    char_t ch;
  } key_result_t;

  typedef enum int {
    ROWS_SPARSE,
    ROWS_HELD,
    ROWS_NOISE
  } row_mode_e;

  class key_scoreboard;
    logic [HistBits-1:0] hist [16];
    col_t                col;
    slot_t               slots [2];
    bit                  wr_ptr;
    bit                  rd_ptr;
    string               keymap_text;
    key_result_t         pending [$];
    int                  errors;

    function new();
      foreach (hist[i]) hist[i] = '0;
      col         = '0;
      slots[0]    = '0;
      slots[1]    = '0;
      wr_ptr      = 1'b0;
      rd_ptr      = 1'b0;
      keymap_text = "DCBA#9630852*741";
      errors      = 0;
    endfunction

    // advance the key state by one accepted command and queue its result
    function void note_command(cmd_e cmd, rows_t rows);
      key_result_t         r;
      idx_t                k;
      logic [HistBits-1:0] h;
      r = '0;
      if (cmd == CMD_TICK) begin
        for (int i = 0; i < 4; i++) begin
          k = {col, 2'(i)};
          h = {hist[k][HistBits-2:0], rows[i]};
          hist[k] = h;
          // ring has no full check, a push may overwrite an unread key
          if (h == HistBits'(1)) begin
            slots[wr_ptr] = {1'b1, k};
            wr_ptr = ~wr_ptr;
          end
        end
        col = col + 2'd1;
      end else if (slots[rd_ptr].valid) begin
        r.key_valid   = 1'b1;
        r.idx         = slots[rd_ptr].idx;
        r.ch          = 7'(keymap_text[r.idx]);
        slots[rd_ptr] = '0;
        rd_ptr        = ~rd_ptr;
      end
      r.col = col;
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(col_t col_o, logic kv_o, idx_t idx_o, char_t ch_o);
      key_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result col=%0d valid=%0b idx=%0d char=%h",
                                  col_o, kv_o, idx_o, ch_o));
      end else begin
        want = pending.pop_front();
        if (col_o !== want.col)
          report_mismatch($sformatf("column_drive %0d, want %0d", col_o, want.col));
        if (kv_o !== want.key_valid)
          report_mismatch($sformatf("key_valid %0b, want %0b", kv_o, want.key_valid));
        if (idx_o !== want.idx)
          report_mismatch($sformatf("key_index %0d, want %0d", idx_o, want.idx));
        if (ch_o !== want.ch)
          report_mismatch($sformatf("key_char %h, want %h", ch_o, want.ch));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  ksd_in_if  in_if ();
  ksd_out_if out_if ();

  keypad_scan_debounce #(
    .HistoryBits(HistBits)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  key_scoreboard sb;
  int            idle_pct  = 0;
  int            stall_pct = 0;
  bit            key_down [16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver side: ready changes at the falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.column_drive, out_if.key_valid, out_if.key_index,
                        out_if.key_char);
    end
  end

  // called just after a falling edge, returns just after the falling edge past the transfer
  task automatic send_command(cmd_e cmd, rows_t rows);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.command = cmd;
    in_if.rows    = rows;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    sb.note_command(cmd, rows);
    @(negedge clk);
  endtask

  function automatic rows_t pick_rows(row_mode_e mode);
    rows_t r;
    idx_t  k;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      k = {sb.col, 2'(i)};
      case (mode)
        ROWS_SPARSE: r[i] = ($urandom_range(7) == 0);
        ROWS_HELD: begin
          // keys go down and up in runs, with an occasional bounce sample
          if ($urandom_range(11) == 0) key_down[k] = ~key_down[k];
          r[i] = key_down[k] ^ ($urandom_range(15) == 0);
        end
        default: r[i] = 1'($urandom_range(1));
      endcase
    end
    return r;
  endfunction

  initial begin
    int        pop_pct;
    int        pick;
    row_mode_e mode;
    sb = new();
    foreach (key_down[i]) key_down[i] = 1'b0;
    pop_pct       = 30;
    mode          = ROWS_SPARSE;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.command = CMD_TICK;
    in_if.rows    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop, four presses at once, overwrite, held keys, drain
    send_command(CMD_POP, 4'hF);
    send_command(CMD_TICK, 4'hF);
    send_command(CMD_TICK, 4'h0);
    send_command(CMD_TICK, 4'h0);
    send_command(CMD_TICK, 4'h8);
    send_command(CMD_POP, 4'h0);
    send_command(CMD_POP, 4'h0);
    send_command(CMD_POP, 4'h0);
    send_command(CMD_TICK, 4'hF);
    send_command(CMD_TICK, 4'h5);
    send_command(CMD_TICK, 4'hA);
    send_command(CMD_TICK, 4'h1);
    send_command(CMD_POP, 4'h0);
    send_command(CMD_TICK, 4'h0);
    send_command(CMD_TICK, 4'h0);
    send_command(CMD_POP, 4'h0);
    send_command(CMD_POP, 4'h0);
    send_command(CMD_POP, 4'h0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      for (int n = 0; n < 500; n++) begin
        if (n % 50 == 0) begin
          pop_pct = $urandom_range(10, 60);
          pick    = $urandom_range(99);
          mode    = (pick < 45) ? ROWS_SPARSE : (pick < 85) ? ROWS_HELD : ROWS_NOISE;
        end
        if ($urandom_range(99) < pop_pct)
          send_command(CMD_POP, 4'($urandom));
        else
          send_command(CMD_TICK, pick_rows(mode));
      end
    end
    in_if.valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ksd_pkg.sv
hdl/ksd_if.sv
hdl/ksd_history.sv
hdl/keypad_scan_debounce.sv
tb/sv/tb_keypad_scan_debounce.sv
